// ----- rtl/core/spqc_pkg.sv -----
// Shared constants and field layout for the swept point quad collision unit.
package spqc_pkg;

    // Default coordinate width of one packed component
    localparam int COORD_WIDTH_DEFAULT = 21;

    // Fraction bits of the unit normal
    localparam int NORM_FRAC = 14;

    // Magnitude width of the cross product after scaling
    localparam int NORM_BITS = 24;

    // Port field widths
    localparam int FIELD_W  = 63;
    localparam int HEIGHT_W = 20;
    localparam int KIND_W   = 2;
    localparam int TOL_W    = 20;
    localparam int CFG_IDX_W = 2;

    // Input and output bus widths, padded to whole bytes
    localparam int S_DATA_W = 400;
    localparam int S_USER_W = 8;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 8;

    // Register reset value
    localparam logic [TOL_W-1:0] TOL_RESET = 20'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_IS_WALL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_FACES_BACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_TOL    = 2'd2;

    // Object kinds; every code from bomb upward has zero radius
    localparam logic [KIND_W-1:0] KIND_PLAYER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHADOW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOMB   = 2'd2;

endpackage

// ----- rtl/core/swept_point_quad_collision_unit.sv -----
// Pipelined test of one moving object against one quad, one request per cycle.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  s_*      | in        | s_tvalid / s_tready       | quad corners, positions, size
//  m_*      | out       | m_tvalid / m_tready       | corrected position, flags
//  cfg_*    | in        | cfg_wr_en                 | mode and tolerance registers
//
// One request enters per cycle while the output is not held; the longest parts of
// the pipeline are the square root (25 stages), the normal division (15 stages)
// and the height division (COORD_WIDTH + 2 stages), all one bit per stage.
// rst_n clears the valid bits and the configuration registers asynchronously.
// A result held at the output freezes the whole pipeline; s_tready falls with it,
// so nothing is dropped or repeated.
module swept_point_quad_collision_unit #(
    parameter int COORD_WIDTH = spqc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // corner_a, corner_b, corner_c, corner_d, position_now, position_before,
    // object_height, zero pad
    input  logic [spqc_pkg::S_DATA_W-1:0]      s_tdata,
    // object_kind, zero pad
    input  logic [spqc_pkg::S_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // position_out, zero pad
    output logic [spqc_pkg::M_DATA_W-1:0]      m_tdata,
    // hit, degenerate_normal, zero pad
    output logic [spqc_pkg::M_USER_W-1:0]      m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [spqc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spqc_pkg::TOL_W-1:0]         cfg_wdata
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int CW   = PW + 1;
    localparam int LW   = $clog2(CW + 1);
    localparam int NB   = spqc_pkg::NORM_BITS;
    localparam int NF   = spqc_pkg::NORM_FRAC;
    localparam int FW   = spqc_pkg::FIELD_W;
    localparam int HW   = spqc_pkg::HEIGHT_W;
    localparam int SQW  = 2 * NB + 2;
    localparam int SQS  = NB + 1;
    localparam int LENW = NB + 1;
    localparam int NUMW = NB + NF + 2;
    localparam int DVS  = NF + 1;
    localparam int NW   = NF + 2;
    localparam int DPW  = NW + DW;
    localparam int DOTW = DPW + 2;
    localparam int WPW  = NW + DOTW;
    localparam int WRW  = WPW - 2 * NF + 2;
    localparam int QB   = W + 2;
    localparam int QW   = QB + 1;
    localparam int YW   = QB + 4;
    localparam int GW   = (YW > WRW + 1) ? YW : WRW + 1;
    localparam int CMPW = ((DOTW > 35) ? DOTW : 35) + 2;
    localparam int XW   = ((DOTW + 1 > NF + 1 + QB) ? DOTW + 1 : NF + 1 + QB) + 1;

    // Stage indexes
    localparam int S_PRD = 1;
    localparam int S_CRS = 2;
    localparam int S_MAG = 3;
    localparam int S_NRM = 4;
    localparam int S_SQR = 5;
    localparam int S_SUM = 6;
    localparam int S_RT0 = 7;
    localparam int S_LEN = S_RT0 + SQS;
    localparam int S_DV0 = S_LEN + 1;
    localparam int S_NV  = S_DV0 + DVS;
    localparam int S_DPR = S_NV + 1;
    localparam int S_DOT = S_DPR + 1;
    localparam int S_DEC = S_DOT + 1;
    localparam int S_FD0 = S_DEC + 1;
    localparam int S_OUT = S_FD0 + QB;

    typedef logic signed [W-1:0]    cv_t;
    typedef logic signed [DW-1:0]   dv_t;
    typedef logic signed [PW-1:0]   pr_t;
    typedef logic signed [CW-1:0]   cw_t;
    typedef logic signed [NW-1:0]   nv_t;
    typedef logic signed [DPW-1:0]  dp_t;
    typedef logic signed [DOTW-1:0] dt_t;
    typedef logic signed [WPW-1:0]  wp_t;
    typedef logic signed [WRW-1:0]  wr_t;
    typedef logic signed [GW-1:0]   gw_t;

    typedef struct packed {
        logic [3*W-1:0] pos;
        cv_t            a_y;
        dv_t [2:0]      ap;
        dv_t [2:0]      aq;
        dv_t [2:0]      mv;
        logic [HW-1:0]  height;
        logic           bomb;
    } ctx_t;

    typedef struct packed {
        logic hit;
        logic degen;
        logic floor_fix;
        logic wall_fix;
    } dec_t;

    // Saturate to the signed coordinate range
    function automatic cv_t sat_c(input gw_t v);
        gw_t hi;
        gw_t lo;
        hi = gw_t'({1'b0, {(W-1){1'b1}}});
        lo = -hi - gw_t'(1);
        if (v > hi)
            return cv_t'(hi);
        else if (v < lo)
            return cv_t'(lo);
        else
            return cv_t'(v);
    endfunction

    // Configuration registers
    logic                       surface_is_wall_reg;
    logic                       wall_faces_back_reg;
    logic [spqc_pkg::TOL_W-1:0] approach_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_is_wall_reg <= 1'b0;
            wall_faces_back_reg <= 1'b0;
            approach_tol_reg    <= spqc_pkg::TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                spqc_pkg::CFG_SURFACE_IS_WALL: surface_is_wall_reg <= cfg_wdata[0];
                spqc_pkg::CFG_WALL_FACES_BACK: wall_faces_back_reg <= cfg_wdata[0];
                spqc_pkg::CFG_APPROACH_TOL:    approach_tol_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline advance: stall everything while a result waits at the output
    logic adv;
    logic vld_reg [0:S_OUT];

    assign adv      = !vld_reg[S_OUT] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[S_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= S_OUT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= S_OUT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Stage 0: unpack and take edge and offset vectors
    dv_t  e_next [4][3];
    dv_t  r_next [4][3];
    ctx_t ctx_next;
    dv_t  e_reg  [4][3];
    dv_t  r_reg  [4][3];
    ctx_t ctx_reg [0:S_OUT-1];

    always_comb
    begin
        cv_t crn [4][3];
        cv_t pn  [3];
        cv_t pb  [3];
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 4; k++)
                crn[k][i] = $signed(s_tdata[k*FW + i*W +: W]);
            pn[i] = $signed(s_tdata[4*FW + i*W +: W]);
            pb[i] = $signed(s_tdata[5*FW + i*W +: W]);
            e_next[0][i] = dv_t'(crn[1][i]) - dv_t'(crn[0][i]);
            e_next[1][i] = dv_t'(crn[3][i]) - dv_t'(crn[1][i]);
            e_next[2][i] = dv_t'(crn[2][i]) - dv_t'(crn[3][i]);
            e_next[3][i] = dv_t'(crn[0][i]) - dv_t'(crn[2][i]);
            r_next[0][i] = dv_t'(pn[i]) - dv_t'(crn[0][i]);
            r_next[1][i] = dv_t'(pn[i]) - dv_t'(crn[1][i]);
            r_next[2][i] = dv_t'(pn[i]) - dv_t'(crn[3][i]);
            r_next[3][i] = dv_t'(pn[i]) - dv_t'(crn[2][i]);
            ctx_next.ap[i] = dv_t'(pn[i]) - dv_t'(crn[0][i]);
            ctx_next.aq[i] = dv_t'(pb[i]) - dv_t'(crn[0][i]);
            ctx_next.mv[i] = dv_t'(pn[i]) - dv_t'(pb[i]);
        end
        ctx_next.pos    = s_tdata[4*FW +: 3*W];
        ctx_next.a_y    = crn[0][1];
        ctx_next.height = s_tdata[6*FW +: HW];
        ctx_next.bomb   = (s_tuser[spqc_pkg::KIND_W-1:0] >= spqc_pkg::KIND_BOMB);
    end

    // Stage 1: cross product terms (plane index 0 XY, 1 ZY, 2 XZ)
    pr_t pa_next [4][3];
    pr_t pb_next [4][3];
    pr_t na_next [3];
    pr_t nb_next [3];
    pr_t pa_reg  [4][3];
    pr_t pb_reg  [4][3];
    pr_t na_reg  [3];
    pr_t nb_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pa_next[k][0] = pr_t'(e_reg[k][0]) * pr_t'(r_reg[k][1]);
            pb_next[k][0] = pr_t'(r_reg[k][0]) * pr_t'(e_reg[k][1]);
            pa_next[k][1] = pr_t'(e_reg[k][2]) * pr_t'(r_reg[k][1]);
            pb_next[k][1] = pr_t'(r_reg[k][2]) * pr_t'(e_reg[k][1]);
            pa_next[k][2] = pr_t'(e_reg[k][0]) * pr_t'(r_reg[k][2]);
            pb_next[k][2] = pr_t'(r_reg[k][0]) * pr_t'(e_reg[k][2]);
        end
        na_next[0] = pr_t'(e_reg[0][1]) * pr_t'(e_reg[1][2]);
        nb_next[0] = pr_t'(e_reg[0][2]) * pr_t'(e_reg[1][1]);
        na_next[1] = pr_t'(e_reg[0][2]) * pr_t'(e_reg[1][0]);
        nb_next[1] = pr_t'(e_reg[0][0]) * pr_t'(e_reg[1][2]);
        na_next[2] = pr_t'(e_reg[0][0]) * pr_t'(e_reg[1][1]);
        nb_next[2] = pr_t'(e_reg[0][1]) * pr_t'(e_reg[1][0]);
    end

    // Stage 2: inside test and normal cross product
    logic ins_next;
    cw_t  c_next [3];
    logic ins_reg [S_CRS:S_DEC-1];
    cw_t  c_reg  [3];

    always_comb
    begin
        cw_t  v;
        logic ok_xy;
        logic ok_zy;
        logic ok_xz;
        ok_xy = 1'b1;
        ok_zy = 1'b1;
        ok_xz = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            v = cw_t'(pa_reg[k][0]) - cw_t'(pb_reg[k][0]);
            ok_xy = ok_xy && (wall_faces_back_reg ? (v > 0) : (v < 0));
            v = cw_t'(pa_reg[k][1]) - cw_t'(pb_reg[k][1]);
            ok_zy = ok_zy && (wall_faces_back_reg ? (v > 0) : (v < 0));
            v = cw_t'(pa_reg[k][2]) - cw_t'(pb_reg[k][2]);
            ok_xz = ok_xz && (v < 0);
        end
        ins_next = surface_is_wall_reg ? (ok_xy || ok_zy) : ok_xz;
        for (int i = 0; i < 3; i++)
            c_next[i] = cw_t'(na_reg[i]) - cw_t'(nb_reg[i]);
    end

    // Stage 3: magnitudes and leading one of the largest
    logic [CW-1:0] mag_next [3];
    logic          cneg_next [3];
    logic          czero_next;
    logic [LW-1:0] bits_next;
    logic [CW-1:0] mag_reg  [3];
    logic          cneg_reg [S_MAG:S_NV-1][3];
    logic          czero_reg [S_MAG:S_NV-1];
    logic [LW-1:0] bits_reg;

    always_comb
    begin
        logic [CW-1:0] orv;
        orv = '0;
        for (int i = 0; i < 3; i++)
        begin
            cneg_next[i] = c_reg[i][CW-1];
            mag_next[i]  = c_reg[i][CW-1] ? CW'(-c_reg[i]) : CW'(c_reg[i]);
            orv = orv | mag_next[i];
        end
        czero_next = (orv == '0);
        bits_next  = '0;
        for (int b = 0; b < CW; b++)
        begin
            if (orv[b])
                bits_next = LW'(b + 1);
        end
    end

    // Stage 4: scale so the largest magnitude fills NB bits
    logic [NB-1:0] m_next [3];
    logic [NB-1:0] mm_reg [S_NRM:S_LEN-1][3];

    always_comb
    begin
        logic [CW+NB-1:0] ext;
        for (int i = 0; i < 3; i++)
        begin
            ext = {{NB{1'b0}}, mag_reg[i]};
            if (bits_reg > LW'(NB))
                ext = ext >> (bits_reg - LW'(NB));
            else
                ext = ext << (LW'(NB) - bits_reg);
            m_next[i] = ext[NB-1:0];
        end
    end

    // Stage 5 and 6: squares and their sum
    logic [2*NB-1:0] sq_next [3];
    logic [2*NB-1:0] sq_reg  [3];
    logic [SQW-1:0]  sum_next;
    logic [SQW-1:0]  sum_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = (2*NB)'(mm_reg[S_SQR-1][i]) * (2*NB)'(mm_reg[S_SQR-1][i]);
        sum_next = SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
    end

    // Square root, one result bit per stage
    logic [SQW-1:0] rt_v_next [0:SQS-1];
    logic [SQW:0]   rt_r_next [0:SQS-1];
    logic [SQW-1:0] rt_v_reg  [0:SQS-1];
    logic [SQW:0]   rt_r_reg  [0:SQS-1];

    always_comb
    begin
        logic [SQW-1:0] v;
        logic [SQW:0]   r;
        logic [SQW:0]   b;
        for (int j = 0; j < SQS; j++)
        begin
            v = (j == 0) ? sum_reg : rt_v_reg[(j == 0) ? 0 : j-1];
            r = (j == 0) ? '0 : rt_r_reg[(j == 0) ? 0 : j-1];
            b = (SQW+1)'(1) << (2 * (SQS - 1 - j));
            if ({1'b0, v} >= r + b)
            begin
                rt_v_next[j] = SQW'({1'b0, v} - (r + b));
                rt_r_next[j] = (r >> 1) + b;
            end
            else
            begin
                rt_v_next[j] = v;
                rt_r_next[j] = r >> 1;
            end
        end
    end

    // Length and rounded numerators for the normal division
    logic [LENW-1:0] dv_len_reg [0:DVS];
    logic [NUMW-1:0] dv_rem_reg [0:DVS][3];
    logic [DVS-1:0]  dv_quo_reg [0:DVS][3];
    logic [LENW-1:0] len_next;
    logic [NUMW-1:0] num_next [3];

    always_comb
    begin
        len_next = rt_r_reg[SQS-1][LENW-1:0];
        for (int i = 0; i < 3; i++)
            num_next[i] = (NUMW'(mm_reg[S_LEN-1][i]) << NF) + NUMW'(len_next >> 1);
    end

    // Normal division, one quotient bit per stage
    logic [NUMW-1:0] dv_rem_next [0:DVS-1][3];
    logic [DVS-1:0]  dv_quo_next [0:DVS-1][3];

    always_comb
    begin
        logic [NUMW-1:0] dsh;
        for (int j = 0; j < DVS; j++)
        begin
            dsh = NUMW'(dv_len_reg[j]) << (DVS - 1 - j);
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_next[j][i] = dv_rem_reg[j][i];
                dv_quo_next[j][i] = dv_quo_reg[j][i];
                if (dv_rem_reg[j][i] >= dsh)
                begin
                    dv_rem_next[j][i] = dv_rem_reg[j][i] - dsh;
                    dv_quo_next[j][i][DVS-1-j] = 1'b1;
                end
            end
        end
    end

    // Signed unit normal
    nv_t nv_next [3];
    nv_t nv_reg  [S_NV:S_DEC-1][3];

    always_comb
    begin
        nv_t q;
        for (int i = 0; i < 3; i++)
        begin
            q = $signed({1'b0, dv_quo_reg[DVS][i]});
            if (czero_reg[S_NV-1])
                nv_next[i] = '0;
            else
                nv_next[i] = cneg_reg[S_NV-1][i] ? -q : q;
        end
    end

    // Dot product terms
    dp_t pd_next [3];
    dp_t po_next [3];
    dp_t pm_next [3];
    dp_t pd_reg  [3];
    dp_t po_reg  [3];
    dp_t pm_reg  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pd_next[i] = dp_t'(nv_reg[S_NV][i]) * dp_t'(ctx_reg[S_DPR-1].ap[i]);
            po_next[i] = dp_t'(nv_reg[S_NV][i]) * dp_t'(ctx_reg[S_DPR-1].aq[i]);
            pm_next[i] = dp_t'(nv_reg[S_NV][i]) * dp_t'(ctx_reg[S_DPR-1].mv[i]);
        end
    end

    // Dot products, floor numerator and wall push factor
    dt_t dn_next;
    dt_t dold_next;
    dt_t fnum_next;
    dt_t fpush_next;
    dt_t dn_reg;
    dt_t dold_reg;
    dt_t fnum_reg;
    dt_t fpush_reg;

    always_comb
    begin
        dn_next    = dt_t'(pd_reg[0]) + dt_t'(pd_reg[1]) + dt_t'(pd_reg[2]);
        dold_next  = dt_t'(po_reg[0]) + dt_t'(po_reg[1]) + dt_t'(po_reg[2]);
        fnum_next  = dt_t'(pd_reg[0]) + dt_t'(pd_reg[2]);
        fpush_next = -(dt_t'(pm_reg[0]) + dt_t'(pm_reg[1]) + dt_t'(pm_reg[2]));
    end

    // Decide the hit; set up the height division and the wall push products
    dec_t            dec_next;
    dec_t            dec_reg [S_DEC:S_OUT-1];
    logic [XW-1:0]   fd_rem_next;
    logic [NF:0]     fd_den_next;
    logic            fd_neg_next;
    logic            fd_ovf_next;
    wp_t             wp_next [3];
    wp_t             wp_reg  [3];
    logic [XW-1:0]   fd_rem_reg [0:QB];
    logic [QB-1:0]   fd_quo_reg [0:QB];
    logic [NF:0]     fd_den_reg [0:QB];
    logic            fd_neg_reg [0:QB];
    logic            fd_ovf_reg [0:QB];

    always_comb
    begin
        logic signed [CMPW-1:0] rad;
        logic signed [CMPW-1:0] tol;
        logic signed [CMPW-1:0] dnx;
        logic signed [CMPW-1:0] dox;
        logic [DOTW-1:0]        nmag;
        nv_t                    ny;
        logic                   near;
        logic                   floor_hit;
        logic                   wall_hit;
        ny   = nv_reg[S_DEC-1][1];
        rad  = ctx_reg[S_DEC-1].bomb ? '0
             : $signed(CMPW'(ctx_reg[S_DEC-1].height) << (NF - 1));
        tol  = $signed(CMPW'(approach_tol_reg) << NF);
        dnx  = CMPW'(dn_reg);
        dox  = CMPW'(dold_reg);
        near = ins_reg[S_DEC-1] && (dnx <= rad);
        floor_hit = !surface_is_wall_reg && near && (dox >= rad - tol);
        wall_hit  = surface_is_wall_reg && near && (dox > -tol);
        dec_next.hit       = floor_hit || wall_hit;
        dec_next.degen     = floor_hit && (ny == '0);
        dec_next.floor_fix = floor_hit && (ny != '0);
        dec_next.wall_fix  = wall_hit && ((dn_reg != '0) || (dold_reg != '0));
        nmag        = fnum_reg[DOTW-1] ? DOTW'(-fnum_reg) : DOTW'(fnum_reg);
        fd_den_next = ny[NW-1] ? (NF+1)'(-ny) : (NF+1)'(ny);
        fd_neg_next = fnum_reg[DOTW-1] ^ ny[NW-1];
        fd_rem_next = XW'(nmag) + XW'(fd_den_next >> 1);
        fd_ovf_next = (fd_rem_next >= (XW'(fd_den_next) << QB));
        for (int i = 0; i < 3; i++)
            wp_next[i] = wp_t'(nv_reg[S_DEC-1][i]) * wp_t'(fpush_reg);
    end

    // Height division, one quotient bit per stage
    logic [XW-1:0] fd_rem_step [0:QB-1];
    logic [QB-1:0] fd_quo_step [0:QB-1];

    always_comb
    begin
        logic [XW-1:0] dsh;
        for (int j = 0; j < QB; j++)
        begin
            dsh = XW'(fd_den_reg[j]) << (QB - 1 - j);
            fd_rem_step[j] = fd_rem_reg[j];
            fd_quo_step[j] = fd_quo_reg[j];
            if (fd_rem_reg[j] >= dsh)
            begin
                fd_rem_step[j] = fd_rem_reg[j] - dsh;
                fd_quo_step[j][QB-1-j] = 1'b1;
            end
        end
    end

    // Round the wall push to coordinate scale
    wr_t wr_next [3];
    wr_t wr_reg  [S_FD0:S_OUT-1][3];

    always_comb
    begin
        logic [WPW-1:0] mg;
        logic [WPW:0]   rnd;
        wr_t            rq;
        for (int i = 0; i < 3; i++)
        begin
            mg  = wp_reg[i][WPW-1] ? WPW'(-wp_reg[i]) : WPW'(wp_reg[i]);
            rnd = ({1'b0, mg} + ((WPW+1)'(1) << (2*NF - 1))) >> (2*NF);
            rq  = $signed(rnd[WRW-1:0]);
            wr_next[i] = wp_reg[i][WPW-1] ? -rq : rq;
        end
    end

    // Final position
    logic [3*W-1:0] pos_next;

    always_comb
    begin
        ctx_t                 cx;
        dec_t                 dc;
        cv_t                  pc [3];
        logic [QW-1:0]        qmag;
        logic signed [YW-1:0] qs;
        logic signed [YW-1:0] py;
        cx   = ctx_reg[S_OUT-1];
        dc   = dec_reg[S_OUT-1];
        for (int i = 0; i < 3; i++)
            pc[i] = $signed(cx.pos[i*W +: W]);
        qmag = fd_ovf_reg[QB] ? (QW'(1) << QB) : QW'(fd_quo_reg[QB]);
        qs   = $signed(YW'(qmag));
        if (fd_neg_reg[QB])
            qs = -qs;
        py   = YW'(cx.a_y) - qs;
        if (!cx.bomb)
            py = py + $signed(YW'(cx.height >> 1));
        pos_next = cx.pos;
        if (dc.floor_fix)
            pos_next[W +: W] = sat_c(gw_t'(py));
        else if (dc.wall_fix)
        begin
            for (int i = 0; i < 3; i++)
                pos_next[i*W +: W] = sat_c(gw_t'(pc[i]) + gw_t'(wr_reg[S_OUT-1][i]));
        end
    end

    // Output register
    logic [3*W-1:0] out_pos_reg;
    logic           out_hit_reg;
    logic           out_degen_reg;

    assign m_tdata = spqc_pkg::M_DATA_W'(out_pos_reg);
    assign m_tuser = spqc_pkg::M_USER_W'({out_degen_reg, out_hit_reg});

    // Advance the payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg      <= e_next;
            r_reg      <= r_next;
            ctx_reg[0] <= ctx_next;
            for (int i = 1; i < S_OUT; i++)
                ctx_reg[i] <= ctx_reg[i-1];
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            na_reg <= na_next;
            nb_reg <= nb_next;
            ins_reg[S_CRS] <= ins_next;
            for (int i = S_CRS + 1; i < S_DEC; i++)
                ins_reg[i] <= ins_reg[i-1];
            c_reg    <= c_next;
            mag_reg  <= mag_next;
            bits_reg <= bits_next;
            cneg_reg[S_MAG]  <= cneg_next;
            czero_reg[S_MAG] <= czero_next;
            for (int i = S_MAG + 1; i < S_NV; i++)
            begin
                cneg_reg[i]  <= cneg_reg[i-1];
                czero_reg[i] <= czero_reg[i-1];
            end
            mm_reg[S_NRM] <= m_next;
            for (int i = S_NRM + 1; i < S_LEN; i++)
                mm_reg[i] <= mm_reg[i-1];
            sq_reg  <= sq_next;
            sum_reg <= sum_next;
            rt_v_reg <= rt_v_next;
            rt_r_reg <= rt_r_next;
            dv_len_reg[0] <= len_next;
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= num_next[i];
                dv_quo_reg[0][i] <= '0;
            end
            for (int j = 0; j < DVS; j++)
            begin
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_rem_reg[j+1] <= dv_rem_next[j];
                dv_quo_reg[j+1] <= dv_quo_next[j];
            end
            nv_reg[S_NV] <= nv_next;
            for (int i = S_NV + 1; i < S_DEC; i++)
                nv_reg[i] <= nv_reg[i-1];
            pd_reg    <= pd_next;
            po_reg    <= po_next;
            pm_reg    <= pm_next;
            dn_reg    <= dn_next;
            dold_reg  <= dold_next;
            fnum_reg  <= fnum_next;
            fpush_reg <= fpush_next;
            dec_reg[S_DEC] <= dec_next;
            for (int i = S_DEC + 1; i < S_OUT; i++)
                dec_reg[i] <= dec_reg[i-1];
            wp_reg <= wp_next;
            fd_rem_reg[0] <= fd_rem_next;
            fd_quo_reg[0] <= '0;
            fd_den_reg[0] <= fd_den_next;
            fd_neg_reg[0] <= fd_neg_next;
            fd_ovf_reg[0] <= fd_ovf_next;
            for (int j = 0; j < QB; j++)
            begin
                fd_rem_reg[j+1] <= fd_rem_step[j];
                fd_quo_reg[j+1] <= fd_quo_step[j];
                fd_den_reg[j+1] <= fd_den_reg[j];
                fd_neg_reg[j+1] <= fd_neg_reg[j];
                fd_ovf_reg[j+1] <= fd_ovf_reg[j];
            end
            wr_reg[S_FD0] <= wr_next;
            for (int i = S_FD0 + 1; i < S_OUT; i++)
                wr_reg[i] <= wr_reg[i-1];
            out_pos_reg   <= pos_next;
            out_hit_reg   <= dec_reg[S_OUT-1].hit;
            out_degen_reg <= dec_reg[S_OUT-1].degen;
        end
    end

endmodule
